>>> src/stti_pkg.sv
// Shared types and constants for the sorted tick table.
// Used by stti_cell, sorted_tick_table_insert_top and the testbench; depends on nothing.
package stti_pkg;

  localparam int unsigned STTI_MAX_ENTRIES = 64;
  localparam int unsigned TICK_W           = 16;
  localparam int unsigned GEM_W            = 8;
  localparam int unsigned TRANS_W          = 8;
  localparam int unsigned IN_TDATA_W       = 32;
  localparam int unsigned OUT_TDATA_W      = 16;

  typedef struct packed {
    logic [TICK_W-1:0]         tick;
    logic [GEM_W-1:0]          gem;
    logic signed [TRANS_W-1:0] trans;
  } stti_entry_t;

  // Per-request strobes broadcast to every cell.
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the new tick
    logic rep_en;  // overwrite the entry whose tick matches
    logic ins_en;  // shift the larger entries up and insert
  } stti_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } stti_state_t;

endpackage

>>> src/stti_cell.sv
// One cell of the sorted tick table: holds one entry and its valid bit.
// Compares against the broadcast request and takes its lower neighbour's
// entry on insert. Depends on stti_pkg.
module stti_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  stti_pkg::stti_ctl_t       ctl,
  input  stti_pkg::stti_entry_t     req,
  input  logic                      prev_valid,
  input  logic                      prev_ge,
  input  stti_pkg::stti_entry_t     prev_entry,
  output logic                      valid,
  output logic                      ge,
  output logic                      eq,
  output logic [stti_pkg::GEM_W-1:0] match_gem,
  output stti_pkg::stti_entry_t     entry
);
  import stti_pkg::*;

  logic cmp_ge;
  logic cmp_eq;

  // An empty cell behaves as if its tick were above every request.
  assign cmp_ge = !valid || (entry.tick >= req.tick);
  assign cmp_eq = valid && (entry.tick == req.tick);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ge    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        ge <= cmp_ge;
        eq <= cmp_eq;
      end
      if (ctl.ins_en && ge) begin
        valid <= prev_ge ? prev_valid : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_gem <= cmp_eq ? entry.gem : '0;
    end
    if (ctl.rep_en && eq) begin
      entry.gem   <= req.gem;
      entry.trans <= req.trans;
    end else if (ctl.ins_en && ge) begin
      // First cell at or above the new tick takes the request, the rest shift.
      entry <= prev_ge ? prev_entry : req;
    end
  end

endmodule

>>> src/sorted_tick_table_insert_top.sv
// Sorted tick table with insert and replace: a row of MAX_ENTRIES cells,
// ordered by tick. Depends on stti_pkg and stti_cell.
//
// Each request is first accepted, then every cell compares its tick with
// the new one in parallel, and then the row either overwrites the matching
// cell or shifts its upper part up by one cell and inserts. The apply step
// waits while an earlier result is still held on the output. The table
// starts empty after reset; a request with a new tick while all cells are
// in use is dropped and flagged as table_full.
module sorted_tick_table_insert_top #(
  parameter int unsigned MAX_ENTRIES = stti_pkg::STTI_MAX_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] tick, [23:16] gem_code, [31:24] transpose
  input  logic [stti_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] was_replaced, [8:1] old_gem_code, [9] table_full, [15:10] zero
  output logic [stti_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import stti_pkg::*;

  stti_state_t state, state_next;
  stti_ctl_t   ctl;
  stti_entry_t req;

  logic             cell_valid [MAX_ENTRIES];
  logic             cell_ge    [MAX_ENTRIES];
  logic             cell_eq    [MAX_ENTRIES];
  logic [GEM_W-1:0] cell_mgem  [MAX_ENTRIES];
  stti_entry_t      cell_entry [MAX_ENTRIES];

  logic             any_eq;
  logic [GEM_W-1:0] old_gem;
  logic             full;
  logic             out_free;
  logic             apply_go;

  logic             res_replaced;
  logic [GEM_W-1:0] res_gem;
  logic             res_full;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
        stti_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctl        (ctl),
          .req        (req),
          .prev_valid (1'b0),
          .prev_ge    (1'b0),
          .prev_entry (req),
          .valid      (cell_valid[g]),
          .ge         (cell_ge[g]),
          .eq         (cell_eq[g]),
          .match_gem  (cell_mgem[g]),
          .entry      (cell_entry[g])
        );
      end else begin : g_rest
        stti_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctl        (ctl),
          .req        (req),
          .prev_valid (cell_valid[g-1]),
          .prev_ge    (cell_ge[g-1]),
          .prev_entry (cell_entry[g-1]),
          .valid      (cell_valid[g]),
          .ge         (cell_ge[g]),
          .eq         (cell_eq[g]),
          .match_gem  (cell_mgem[g]),
          .entry      (cell_entry[g])
        );
      end
    end
  endgenerate

  // At most one cell matches, so an OR gathers its gem code.
  always_comb begin
    any_eq  = 1'b0;
    old_gem = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      any_eq  = any_eq | cell_eq[i];
      old_gem = old_gem | cell_mgem[i];
    end
  end

  assign full     = cell_valid[MAX_ENTRIES-1];
  assign out_free = !m_tvalid || m_tready;
  assign apply_go = (state == ST_APPLY) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp_en = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        // Hold until the previous result has been taken.
        if (out_free) begin
          ctl.rep_en = any_eq;
          ctl.ins_en = !any_eq && !full;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.tick  <= s_tdata[TICK_W-1:0];
      req.gem   <= s_tdata[TICK_W+GEM_W-1:TICK_W];
      req.trans <= s_tdata[TICK_W+GEM_W+TRANS_W-1:TICK_W+GEM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      res_replaced <= any_eq;
      res_gem      <= old_gem;
      res_full     <= !any_eq && full;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-GEM_W-2){1'b0}}, res_full, res_gem, res_replaced};

endmodule

>>> dv/sorted_tick_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sorted tick table: mirrors the table from accepted requests
// and compares every result against it. Depends on stti_pkg only.
module sorted_tick_table_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [stti_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [stti_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output int unsigned                         mismatch_count,
  output int unsigned                         pending_results
);
  import stti_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Laid out as m_tdata[9:0], lowest bit last.
  typedef struct packed {
    logic             table_full;
    logic [GEM_W-1:0] old_gem;
    logic             was_replaced;
  } insert_result_t;

  stti_entry_t    mirror_row [STTI_MAX_ENTRIES];
  int             mirror_count;
  insert_result_t awaited_results [$];
  int unsigned    result_index;

  // Apply one request to the mirror and return the result it must produce.
  function automatic insert_result_t mirror_insert(input stti_entry_t ent);
    insert_result_t res;
    int             slot;
    res  = '0;
    slot = mirror_count;
    // Scan downward so the lowest entry with tick >= new tick wins.
    for (int k = mirror_count - 1; k >= 0; k--) begin
      if (mirror_row[k].tick >= ent.tick) slot = k;
    end
    if (slot < mirror_count && mirror_row[slot].tick == ent.tick) begin
      res.was_replaced       = 1'b1;
      res.old_gem            = mirror_row[slot].gem;
      mirror_row[slot].gem   = ent.gem;
      mirror_row[slot].trans = ent.trans;
    end else if (mirror_count >= int'(STTI_MAX_ENTRIES)) begin
      res.table_full = 1'b1;
    end else begin
      for (int k = mirror_count; k > slot; k--) mirror_row[k] = mirror_row[k-1];
      mirror_row[slot] = ent;
      mirror_count++;
    end
    return res;
  endfunction

  task automatic log_mismatch(input string what);
    if (mismatch_count < REPORT_LIMIT) $display("%0t checker: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : scoreboard
    stti_entry_t    req;
    insert_result_t got;
    insert_result_t want;
    if (rst) begin
      mirror_count = 0;
      awaited_results.delete();
      result_index    = 0;
      mismatch_count  = 0;
      pending_results = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        req.tick  = s_tdata[15:0];
        req.gem   = s_tdata[23:16];
        req.trans = s_tdata[31:24];
        awaited_results = {awaited_results, mirror_insert(req)};
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[9:0];
        if (awaited_results.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with none awaited: rep=%0b old=%02h full=%0b",
                                 result_index, got.was_replaced, got.old_gem, got.table_full));
        end else begin
          want = awaited_results.pop_front();
          if (got.was_replaced !== want.was_replaced || got.old_gem !== want.old_gem ||
              got.table_full !== want.table_full)
            log_mismatch($sformatf(
              "result %0d expected rep=%0b old=%02h full=%0b, got rep=%0b old=%02h full=%0b",
              result_index, want.was_replaced, want.old_gem, want.table_full,
              got.was_replaced, got.old_gem, got.table_full));
        end
        result_index++;
      end
      pending_results = awaited_results.size();
    end
  end

endmodule

>>> dv/tb_sorted_tick_table_insert_top.sv
`timescale 1ns / 1ps
// Top of the sorted tick table regression: clock, reset, request and result
// drivers and the verdict. Depends on stti_pkg, the block and its checker.
module tb_sorted_tick_table_insert_top;
  import stti_pkg::*;

  localparam int unsigned RANDOM_REQUESTS  = 534;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES     = 8;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned stall_cycles;
  bit          steady_flow;
  bit          sink_hold_req;
  bit          full_cases_done;

  // Ticks known to be in the table, kept for shaping the stimulus.
  logic [TICK_W-1:0] live_ticks [$];

  sorted_tick_table_insert_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_tick_table_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit tick_is_live(input logic [TICK_W-1:0] t);
    foreach (live_ticks[k]) begin
      if (live_ticks[k] == t) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Pick a tick not yet in the table: anywhere, next to a stored one, or in a
  // crowded band at either end.
  function automatic logic [TICK_W-1:0] fresh_tick();
    logic [TICK_W-1:0] t;
    do begin
      case ($urandom_range(0, 3))
        0: t = 16'($urandom_range(0, 65535));
        1: begin
          if (live_ticks.size() == 0) t = 16'($urandom);
          else t = live_ticks[$urandom_range(0, live_ticks.size() - 1)] +
                   ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
        end
        2: t = 16'($urandom_range(0, 511));
        default: t = 16'($urandom_range(65024, 65535));
      endcase
    end while (tick_is_live(t));
    return t;
  endfunction

  task automatic send_req(input logic [TICK_W-1:0] t, input logic [GEM_W-1:0] g,
                          input logic [TRANS_W-1:0] tr);
    if (!tick_is_live(t) && live_ticks.size() < STTI_MAX_ENTRIES) live_ticks = {live_ticks, t};
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tr, g, t};
    do @(posedge clk); while (!s_tready);
  endtask

  // Lower valid and hold until every awaited result has come back.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
        sink_hold_req = 1'b0;
      end else begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [TICK_W-1:0] t;
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    steady_flow     = 1'b0;
    sink_hold_req   = 1'b0;
    full_cases_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, append at the top, insert at the front and in the middle.
    send_req(16'h8000, 8'h00, 8'h00);
    send_req(16'hFFFF, 8'hFF, 8'h80);
    send_req(16'h0000, 8'h01, 8'h7F);
    send_req(16'h4000, 8'h3C, 8'hC3);
    // Overwrite the last, first and middle entries; the middle one held gem 0.
    send_req(16'hFFFF, 8'hAA, 8'hFF);
    send_req(16'h0000, 8'h55, 8'h01);
    send_req(16'h8000, 8'h80, 8'h7F);
    // Neighbours of stored ticks.
    send_req(16'h7FFF, 8'h0F, 8'hF0);
    send_req(16'h8001, 8'hF0, 8'h0F);
    send_req(16'hFFFE, 8'h99, 8'h66);
    send_req(16'h0001, 8'h66, 8'h99);
    send_req(16'h8000, 8'h12, 8'h34);
    // Same tick twice in a row, then both sides of it.
    send_req(16'h1234, 8'hDE, 8'hAD);
    send_req(16'h1234, 8'hBE, 8'hEF);
    send_req(16'h1233, 8'h00, 8'h80);
    send_req(16'h1235, 8'hFF, 8'h7F);
    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 60 || n == 420) drain_results();
      if (n == 150) steady_flow = 1'b1;
      if (n == 260) steady_flow = 1'b0;
      // Keep offering requests while the result side is blocked.
      if (n == 320) sink_hold_req = 1'b1;
      if (live_ticks.size() == STTI_MAX_ENTRIES && !full_cases_done) begin
        // Full table: overwrite at both ends, then drop a new tick.
        send_req(16'h0000, 8'($urandom), 8'($urandom));
        send_req(16'hFFFF, 8'($urandom), 8'($urandom));
        send_req(fresh_tick(), 8'($urandom), 8'($urandom));
        full_cases_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 5)
        t = 16'($urandom_range(0, 65535));
      else if (live_ticks.size() != 0 &&
               $urandom_range(0, 99) < (live_ticks.size() < STTI_MAX_ENTRIES ? 35 : 50))
        t = live_ticks[$urandom_range(0, live_ticks.size() - 1)];
      else
        t = fresh_tick();
      send_req(t, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
